[hdl/tqps_pkg.sv]
`default_nettype none

package tqps_pkg;

   // field widths fixed by the interface
   localparam int CMD_W   = 2;
   localparam int IDENT_W = 16;
   localparam int TIME_W  = 32;
   localparam int FILL_W  = 5;
   localparam int CNT_W   = 32;
   localparam int SUM_W   = 64;
   localparam int OUTC_W  = 3;
   localparam int ENTRY_W = IDENT_W + TIME_W;

   // largest value the limit register can hold
   localparam int LIMIT_MAX = (1 << FILL_W) - 1;
   localparam logic [FILL_W-1:0] LIMIT_RESET = FILL_W'(16);

   // command decoding: upper bit marks a service tick, lower bit picks the queue
   localparam int CMD_TICK_BIT = 1;
   localparam int CMD_LOW_BIT  = 0;

   // result outcome codes
   typedef enum logic [OUTC_W-1:0] {
      OUTC_ACCEPTED    = 3'd0,
      OUTC_REFUSED     = 3'd1,
      OUTC_HIGH_SERVED = 3'd2,
      OUTC_LOW_SERVED  = 3'd3,
      OUTC_IDLE        = 3'd4
   } outcome_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_SERVE = 2'b10
   } state_type;

   // control from the sequencer to one queue
   typedef struct packed {
      logic push;
      logic pop;
   } q_ctl_type;

endpackage

`default_nettype wire

[hdl/tqps_queue.sv]
`default_nettype none

module tqps_queue #(
   parameter int DEPTH = 16
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire  tqps_pkg::q_ctl_type        ctl,
   input  wire  [tqps_pkg::ENTRY_W-1:0]     wr_data,
   output logic [tqps_pkg::ENTRY_W-1:0]     rd_data,
   output logic [tqps_pkg::FILL_W-1:0]      fill
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [tqps_pkg::ENTRY_W-1:0] store_ff [DEPTH];
   logic [tqps_pkg::ENTRY_W-1:0] rd_data_ff;
   logic [PTR_W-1:0]             head_ff, head_in;
   logic [PTR_W-1:0]             tail_ff, tail_in;
   logic [tqps_pkg::FILL_W-1:0]  fill_ff, fill_in;

   // entry store: one write or one registered read per cycle
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         store_ff[tail_ff] <= wr_data;
      end
      if (ctl.pop) begin
         rd_data_ff <= store_ff[head_ff];
      end
   end

   // pointer and fill update
   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      fill_in = fill_ff;
      if (ctl.push) begin
         tail_in = (tail_ff == LAST) ? '0 : tail_ff + PTR_W'(1);
         fill_in = fill_ff + tqps_pkg::FILL_W'(1);
      end else if (ctl.pop) begin
         head_in = (head_ff == LAST) ? '0 : head_ff + PTR_W'(1);
         fill_in = fill_ff - tqps_pkg::FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

   assign rd_data = rd_data_ff;
   assign fill    = fill_ff;

endmodule

`default_nettype wire

[hdl/two_queue_priority_server.sv]
`default_nettype none

// Strict-priority server over two FIFO queues held in synchronous RAM. A request
// (command 0 high, 1 low) joins its queue unless the queue already holds at
// least min(entry limit, QUEUE_DEPTH) entries; a tick (command 2 or 3) serves
// the head of the high queue, else the low queue, else counts an idle tick. Every
// transaction gives exactly one result carrying the outcome, the served ident
// and wait, both queue fills and the saturating statistics. One transaction is
// in flight at a time: requests and idle ticks put their result in the output
// register on the acceptance edge and the next transaction can be taken in the
// following cycle unless rsp_stall holds that result; a tick that serves an
// entry finishes in ST_SERVE after the registered queue read. A result held by
// rsp_stall blocks new transactions. The entry limit is written through the csr_
// port, which is ready whenever reset is low, and must only be written while the
// block is idle. Both input channels are held off while reset is high.
module two_queue_priority_server #(
   parameter int QUEUE_DEPTH = 16
) (
   input  wire                               clock,
   input  wire                               reset,
   // configuration
   input  wire                               csr_valid,
   output logic                              csr_ready,
   input  wire  [tqps_pkg::FILL_W-1:0]       csr_data,
   // request channel
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [tqps_pkg::CMD_W-1:0]        req_command,
   input  wire  [tqps_pkg::IDENT_W-1:0]      req_ident,
   input  wire  [tqps_pkg::TIME_W-1:0]       req_now,
   // result channel
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [tqps_pkg::OUTC_W-1:0]       rsp_outcome,
   output logic [tqps_pkg::IDENT_W-1:0]      rsp_served_ident,
   output logic [tqps_pkg::TIME_W-1:0]       rsp_served_wait,
   output logic [tqps_pkg::FILL_W-1:0]       rsp_high_count,
   output logic [tqps_pkg::FILL_W-1:0]       rsp_low_count,
   output logic [tqps_pkg::CNT_W-1:0]        rsp_high_refused_total,
   output logic [tqps_pkg::CNT_W-1:0]        rsp_low_refused_total,
   output logic [tqps_pkg::CNT_W-1:0]        rsp_high_served_total,
   output logic [tqps_pkg::CNT_W-1:0]        rsp_low_served_total,
   output logic [tqps_pkg::CNT_W-1:0]        rsp_idle_total,
   output logic [tqps_pkg::SUM_W-1:0]        rsp_high_wait_total,
   output logic [tqps_pkg::SUM_W-1:0]        rsp_low_wait_total
);

   localparam int LIM_CAP = (QUEUE_DEPTH < tqps_pkg::LIMIT_MAX) ?
                            QUEUE_DEPTH : tqps_pkg::LIMIT_MAX;
   localparam logic [tqps_pkg::FILL_W-1:0] CAP = tqps_pkg::FILL_W'(LIM_CAP);

   tqps_pkg::state_type            state_ff, state_in;
   logic [tqps_pkg::FILL_W-1:0]    limit_ff;
   logic                           pick_low_ff, pick_low_in;
   logic [tqps_pkg::TIME_W-1:0]    tick_now_ff, tick_now_in;

   tqps_pkg::q_ctl_type            high_ctl, low_ctl;
   logic [tqps_pkg::ENTRY_W-1:0]   high_rd, low_rd, wr_entry;
   logic [tqps_pkg::FILL_W-1:0]    high_fill, low_fill, eff_limit;

   logic [tqps_pkg::CNT_W-1:0]     href_ff, href_in, lref_ff, lref_in;
   logic [tqps_pkg::CNT_W-1:0]     hsrv_ff, hsrv_in, lsrv_ff, lsrv_in;
   logic [tqps_pkg::CNT_W-1:0]     idle_ff, idle_in;
   logic [tqps_pkg::SUM_W-1:0]     hsum_ff, hsum_in, lsum_ff, lsum_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   tqps_pkg::outcome_type          outcome_ff, outcome_in;
   logic [tqps_pkg::IDENT_W-1:0]   s_ident_ff, s_ident_in;
   logic [tqps_pkg::TIME_W-1:0]    s_wait_ff, s_wait_in;
   logic [tqps_pkg::FILL_W-1:0]    hcnt_ff, hcnt_in, lcnt_ff, lcnt_in;

   logic                           out_free, accept, is_tick, is_low;
   logic [tqps_pkg::ENTRY_W-1:0]   head_entry;
   logic [tqps_pkg::TIME_W-1:0]    wait_val;
   logic [tqps_pkg::SUM_W:0]       sum_wide;
   logic [tqps_pkg::SUM_W-1:0]     sum_base, sum_sat;

   function automatic logic [tqps_pkg::CNT_W-1:0] sat_inc(
      input logic [tqps_pkg::CNT_W-1:0] c
   );
      return (&c) ? c : c + tqps_pkg::CNT_W'(1);
   endfunction

   // queues
   tqps_queue #(.DEPTH(QUEUE_DEPTH)) u_high (
      .clock   (clock),
      .reset   (reset),
      .ctl     (high_ctl),
      .wr_data (wr_entry),
      .rd_data (high_rd),
      .fill    (high_fill)
   );

   tqps_queue #(.DEPTH(QUEUE_DEPTH)) u_low (
      .clock   (clock),
      .reset   (reset),
      .ctl     (low_ctl),
      .wr_data (wr_entry),
      .rd_data (low_rd),
      .fill    (low_fill)
   );

   // handshake
   assign csr_ready = !reset;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = reset || !((state_ff == tqps_pkg::ST_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;
   assign is_tick   = req_command[tqps_pkg::CMD_TICK_BIT];
   assign is_low    = req_command[tqps_pkg::CMD_LOW_BIT];
   assign wr_entry  = {req_ident, req_now};

   // effective limit is capped at the queue depth
   assign eff_limit = (limit_ff > CAP) ? CAP : limit_ff;

   // served entry and its wait, saturating wait sum
   assign head_entry = pick_low_ff ? low_rd : high_rd;
   assign wait_val   = tick_now_ff - head_entry[tqps_pkg::TIME_W-1:0];
   assign sum_base   = pick_low_ff ? lsum_ff : hsum_ff;
   assign sum_wide   = {1'b0, sum_base} + {{(tqps_pkg::SUM_W + 1 - tqps_pkg::TIME_W){1'b0}},
                                           wait_val};
   assign sum_sat    = sum_wide[tqps_pkg::SUM_W] ? '1 : sum_wide[tqps_pkg::SUM_W-1:0];

   // sequencer
   always_comb begin
      state_in     = state_ff;
      pick_low_in  = pick_low_ff;
      tick_now_in  = tick_now_ff;
      high_ctl     = '0;
      low_ctl      = '0;
      href_in      = href_ff;
      lref_in      = lref_ff;
      hsrv_in      = hsrv_ff;
      lsrv_in      = lsrv_ff;
      idle_in      = idle_ff;
      hsum_in      = hsum_ff;
      lsum_in      = lsum_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      outcome_in   = outcome_ff;
      s_ident_in   = s_ident_ff;
      s_wait_in    = s_wait_ff;
      hcnt_in      = hcnt_ff;
      lcnt_in      = lcnt_ff;
      case (state_ff)
         tqps_pkg::ST_IDLE: begin
            if (accept) begin
               s_ident_in = '0;
               s_wait_in  = '0;
               hcnt_in    = high_fill;
               lcnt_in    = low_fill;
               if (!is_tick) begin
                  // request transaction
                  rsp_valid_in = 1'b1;
                  if (!is_low) begin
                     if (high_fill < eff_limit) begin
                        high_ctl.push = 1'b1;
                        hcnt_in       = high_fill + tqps_pkg::FILL_W'(1);
                        outcome_in    = tqps_pkg::OUTC_ACCEPTED;
                     end else begin
                        href_in    = sat_inc(href_ff);
                        outcome_in = tqps_pkg::OUTC_REFUSED;
                     end
                  end else begin
                     if (low_fill < eff_limit) begin
                        low_ctl.push = 1'b1;
                        lcnt_in      = low_fill + tqps_pkg::FILL_W'(1);
                        outcome_in   = tqps_pkg::OUTC_ACCEPTED;
                     end else begin
                        lref_in    = sat_inc(lref_ff);
                        outcome_in = tqps_pkg::OUTC_REFUSED;
                     end
                  end
               end else if (high_fill != '0) begin
                  // serve high: read head, finish next cycle
                  high_ctl.pop = 1'b1;
                  pick_low_in  = 1'b0;
                  tick_now_in  = req_now;
                  state_in     = tqps_pkg::ST_SERVE;
               end else if (low_fill != '0) begin
                  low_ctl.pop  = 1'b1;
                  pick_low_in  = 1'b1;
                  tick_now_in  = req_now;
                  state_in     = tqps_pkg::ST_SERVE;
               end else begin
                  rsp_valid_in = 1'b1;
                  idle_in      = sat_inc(idle_ff);
                  outcome_in   = tqps_pkg::OUTC_IDLE;
               end
            end
         end
         tqps_pkg::ST_SERVE: begin
            // output register is free here: it was free when the tick was taken
            rsp_valid_in = 1'b1;
            s_ident_in   = head_entry[tqps_pkg::ENTRY_W-1:tqps_pkg::TIME_W];
            s_wait_in    = wait_val;
            hcnt_in      = high_fill;
            lcnt_in      = low_fill;
            state_in     = tqps_pkg::ST_IDLE;
            if (pick_low_ff) begin
               lsum_in    = sum_sat;
               lsrv_in    = sat_inc(lsrv_ff);
               outcome_in = tqps_pkg::OUTC_LOW_SERVED;
            end else begin
               hsum_in    = sum_sat;
               hsrv_in    = sat_inc(hsrv_ff);
               outcome_in = tqps_pkg::OUTC_HIGH_SERVED;
            end
         end
         default: begin
            state_in = tqps_pkg::ST_IDLE;
         end
      endcase
   end

   // control and statistics registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tqps_pkg::ST_IDLE;
         limit_ff     <= tqps_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
         href_ff      <= '0;
         lref_ff      <= '0;
         hsrv_ff      <= '0;
         lsrv_ff      <= '0;
         idle_ff      <= '0;
         hsum_ff      <= '0;
         lsum_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         href_ff      <= href_in;
         lref_ff      <= lref_in;
         hsrv_ff      <= hsrv_in;
         lsrv_ff      <= lsrv_in;
         idle_ff      <= idle_in;
         hsum_ff      <= hsum_in;
         lsum_ff      <= lsum_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pick_low_ff <= pick_low_in;
      tick_now_ff <= tick_now_in;
      outcome_ff  <= outcome_in;
      s_ident_ff  <= s_ident_in;
      s_wait_ff   <= s_wait_in;
      hcnt_ff     <= hcnt_in;
      lcnt_ff     <= lcnt_in;
   end

   // result transaction
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_outcome            = outcome_ff;
   assign rsp_served_ident       = s_ident_ff;
   assign rsp_served_wait        = s_wait_ff;
   assign rsp_high_count         = hcnt_ff;
   assign rsp_low_count          = lcnt_ff;
   assign rsp_high_refused_total = href_ff;
   assign rsp_low_refused_total  = lref_ff;
   assign rsp_high_served_total  = hsrv_ff;
   assign rsp_low_served_total   = lsrv_ff;
   assign rsp_idle_total         = idle_ff;
   assign rsp_high_wait_total    = hsum_ff;
   assign rsp_low_wait_total     = lsum_ff;

endmodule

`default_nettype wire

[sim/two_queue_priority_server_tb.sv]
`timescale 1ns / 1ps

module two_queue_priority_server_tb;

   localparam int DEPTH       = 16;
   localparam int PERIOD      = 10;
   localparam int STALL_LIMIT = 2000;
   localparam int HOLD_CYCLES = 300;
   localparam int CFG_SETTLE  = 3;

   localparam logic [tqps_pkg::CMD_W-1:0] CMD_HIGH_REQ = 2'd0;
   localparam logic [tqps_pkg::CMD_W-1:0] CMD_LOW_REQ  = 2'd1;
   localparam logic [tqps_pkg::CMD_W-1:0] CMD_TICK     = 2'd2;
   localparam logic [tqps_pkg::CMD_W-1:0] CMD_TICK_ALT = 2'd3;

   // one queued request as the shadow queues hold it
   typedef struct {
      logic [tqps_pkg::IDENT_W-1:0] ident;
      logic [tqps_pkg::TIME_W-1:0]  arrival;
   } queued_entry_type;

   // everything one transaction reports
   typedef struct {
      tqps_pkg::outcome_type        outcome;
      logic [tqps_pkg::IDENT_W-1:0] ident;
      logic [tqps_pkg::TIME_W-1:0]  wait_time;
      logic [tqps_pkg::FILL_W-1:0]  high_count;
      logic [tqps_pkg::FILL_W-1:0]  low_count;
      logic [tqps_pkg::CNT_W-1:0]   high_refused;
      logic [tqps_pkg::CNT_W-1:0]   low_refused;
      logic [tqps_pkg::CNT_W-1:0]   high_served;
      logic [tqps_pkg::CNT_W-1:0]   low_served;
      logic [tqps_pkg::CNT_W-1:0]   idle_ticks;
      logic [tqps_pkg::SUM_W-1:0]   high_wait_sum;
      logic [tqps_pkg::SUM_W-1:0]   low_wait_sum;
   } server_result_type;

   // shadow of the server: its own queues, limit and statistics
   class server_shadow;
      queued_entry_type  high_q[$];
      queued_entry_type  low_q[$];
      logic [tqps_pkg::FILL_W-1:0] limit;
      server_result_type stats;
      server_result_type expected_results[$];
      int errors;

      function new();
         limit = tqps_pkg::LIMIT_RESET;
         stats.high_refused  = '0;
         stats.low_refused   = '0;
         stats.high_served   = '0;
         stats.low_served    = '0;
         stats.idle_ticks    = '0;
         stats.high_wait_sum = '0;
         stats.low_wait_sum  = '0;
         errors = 0;
      endfunction

      function void set_limit(logic [tqps_pkg::FILL_W-1:0] value);
         limit = value;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      function logic [tqps_pkg::CNT_W-1:0] bump(logic [tqps_pkg::CNT_W-1:0] count);
         return (count == '1) ? count : count + 1'b1;
      endfunction

      function logic [tqps_pkg::SUM_W-1:0] add_wait(logic [tqps_pkg::SUM_W-1:0] sum,
                                                     logic [tqps_pkg::TIME_W-1:0] value);
         logic [tqps_pkg::SUM_W:0] total;
         total = {1'b0, sum} + value;
         return total[tqps_pkg::SUM_W] ? '1 : total[tqps_pkg::SUM_W-1:0];
      endfunction

      // work out the result of an accepted transaction
      function void note_request(logic [tqps_pkg::CMD_W-1:0] cmd,
                                 logic [tqps_pkg::IDENT_W-1:0] ident,
                                 logic [tqps_pkg::TIME_W-1:0] now);
         server_result_type r;
         queued_entry_type  e;
         int cap;
         cap = (limit > DEPTH) ? DEPTH : int'(limit);
         e.ident = ident;
         e.arrival = now;
         r = stats;
         r.outcome = tqps_pkg::OUTC_ACCEPTED;
         r.ident = '0;
         r.wait_time = '0;
         if (!cmd[tqps_pkg::CMD_TICK_BIT] && !cmd[tqps_pkg::CMD_LOW_BIT]) begin
            if (high_q.size() < cap) begin
               high_q.push_back(e);
            end else begin
               r.outcome = tqps_pkg::OUTC_REFUSED;
               stats.high_refused = bump(stats.high_refused);
            end
         end else if (!cmd[tqps_pkg::CMD_TICK_BIT]) begin
            if (low_q.size() < cap) begin
               low_q.push_back(e);
            end else begin
               r.outcome = tqps_pkg::OUTC_REFUSED;
               stats.low_refused = bump(stats.low_refused);
            end
         end else if (high_q.size() != 0) begin
            e = high_q.pop_front();
            r.outcome = tqps_pkg::OUTC_HIGH_SERVED;
            r.ident = e.ident;
            r.wait_time = now - e.arrival;
            stats.high_wait_sum = add_wait(stats.high_wait_sum, r.wait_time);
            stats.high_served = bump(stats.high_served);
         end else if (low_q.size() != 0) begin
            e = low_q.pop_front();
            r.outcome = tqps_pkg::OUTC_LOW_SERVED;
            r.ident = e.ident;
            r.wait_time = now - e.arrival;
            stats.low_wait_sum = add_wait(stats.low_wait_sum, r.wait_time);
            stats.low_served = bump(stats.low_served);
         end else begin
            r.outcome = tqps_pkg::OUTC_IDLE;
            stats.idle_ticks = bump(stats.idle_ticks);
         end
         r.high_count    = tqps_pkg::FILL_W'(high_q.size());
         r.low_count     = tqps_pkg::FILL_W'(low_q.size());
         r.high_refused  = stats.high_refused;
         r.low_refused   = stats.low_refused;
         r.high_served   = stats.high_served;
         r.low_served    = stats.low_served;
         r.idle_ticks    = stats.idle_ticks;
         r.high_wait_sum = stats.high_wait_sum;
         r.low_wait_sum  = stats.low_wait_sum;
         expected_results.push_back(r);
      endfunction

      function void compare_field(string name, logic [tqps_pkg::SUM_W-1:0] want,
                                  logic [tqps_pkg::SUM_W-1:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         end
      endfunction

      // compare a delivered transaction with the oldest expectation
      function void check_result(server_result_type got);
         server_result_type want;
         if (expected_results.size() == 0) begin
            errors++;
            $display("%0t: result with nothing expected, expected none, actual outcome %0h",
                     $time, got.outcome);
            return;
         end
         want = expected_results.pop_front();
         compare_field("outcome", want.outcome, got.outcome);
         compare_field("served_ident", want.ident, got.ident);
         compare_field("served_wait", want.wait_time, got.wait_time);
         compare_field("high_count", want.high_count, got.high_count);
         compare_field("low_count", want.low_count, got.low_count);
         compare_field("high_refused_total", want.high_refused, got.high_refused);
         compare_field("low_refused_total", want.low_refused, got.low_refused);
         compare_field("high_served_total", want.high_served, got.high_served);
         compare_field("low_served_total", want.low_served, got.low_served);
         compare_field("idle_total", want.idle_ticks, got.idle_ticks);
         compare_field("high_wait_total", want.high_wait_sum, got.high_wait_sum);
         compare_field("low_wait_total", want.low_wait_sum, got.low_wait_sum);
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [tqps_pkg::FILL_W-1:0]   csr_data = '0;

   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [tqps_pkg::CMD_W-1:0]    req_command = '0;
   logic [tqps_pkg::IDENT_W-1:0]  req_ident = '0;
   logic [tqps_pkg::TIME_W-1:0]   req_now = '0;

   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [tqps_pkg::OUTC_W-1:0]   rsp_outcome;
   logic [tqps_pkg::IDENT_W-1:0]  rsp_served_ident;
   logic [tqps_pkg::TIME_W-1:0]   rsp_served_wait;
   logic [tqps_pkg::FILL_W-1:0]   rsp_high_count;
   logic [tqps_pkg::FILL_W-1:0]   rsp_low_count;
   logic [tqps_pkg::CNT_W-1:0]    rsp_high_refused_total;
   logic [tqps_pkg::CNT_W-1:0]    rsp_low_refused_total;
   logic [tqps_pkg::CNT_W-1:0]    rsp_high_served_total;
   logic [tqps_pkg::CNT_W-1:0]    rsp_low_served_total;
   logic [tqps_pkg::CNT_W-1:0]    rsp_idle_total;
   logic [tqps_pkg::SUM_W-1:0]    rsp_high_wait_total;
   logic [tqps_pkg::SUM_W-1:0]    rsp_low_wait_total;

   server_shadow      board;
   server_result_type seen;
   bit                quiet = 1'b0;
   int                hold_req = 0;
   int                hold_left = 0;
   int                burst_left = 0;
   int                idle_cycles = 0;
   logic [tqps_pkg::TIME_W-1:0] stamp;

   two_queue_priority_server #(
      .QUEUE_DEPTH(DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data(csr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_ident(req_ident),
      .req_now(req_now),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_outcome(rsp_outcome),
      .rsp_served_ident(rsp_served_ident),
      .rsp_served_wait(rsp_served_wait),
      .rsp_high_count(rsp_high_count),
      .rsp_low_count(rsp_low_count),
      .rsp_high_refused_total(rsp_high_refused_total),
      .rsp_low_refused_total(rsp_low_refused_total),
      .rsp_high_served_total(rsp_high_served_total),
      .rsp_low_served_total(rsp_low_served_total),
      .rsp_idle_total(rsp_idle_total),
      .rsp_high_wait_total(rsp_high_wait_total),
      .rsp_low_wait_total(rsp_low_wait_total)
   );

   always #(PERIOD / 2) clock = ~clock;

   // offer one transaction, with an occasional gap in front, and note it once taken
   task automatic send_item(logic [tqps_pkg::CMD_W-1:0] cmd,
                            logic [tqps_pkg::IDENT_W-1:0] ident,
                            logic [tqps_pkg::TIME_W-1:0] now);
      if (!quiet && $urandom_range(7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_ident   <= ident;
      req_now     <= now;
      do @(posedge clock); while (req_stall);
      board.note_request(cmd, ident, now);
   endtask

   // stop offering until every outstanding transaction has come back
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (board.pending() != 0);
   endtask

   // queue limit is only changed with the block idle
   task automatic write_limit(logic [tqps_pkg::FILL_W-1:0] value);
      pause_until_drained();
      repeat (CFG_SETTLE) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      board.set_limit(value);
   endtask

   // random arrival times: mostly a slowly advancing clock, sometimes anything
   task automatic random_item(int push_pct);
      logic [tqps_pkg::CMD_W-1:0] cmd;
      logic [tqps_pkg::TIME_W-1:0] now;
      if ($urandom_range(99) < push_pct)
         cmd = $urandom_range(1) ? CMD_LOW_REQ : CMD_HIGH_REQ;
      else
         cmd = $urandom_range(1) ? CMD_TICK_ALT : CMD_TICK;
      stamp = stamp + $urandom_range(0, 40);
      now = ($urandom_range(7) == 0) ? tqps_pkg::TIME_W'($urandom) : stamp;
      send_item(cmd, tqps_pkg::IDENT_W'($urandom), now);
   endtask

   // result side stall: random bursts, long hold-off on request, none when quiet
   always @(posedge clock) begin
      if (hold_req != 0) begin
         hold_left = hold_req;
         hold_req = 0;
      end
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else if (burst_left != 0) begin
         burst_left = burst_left - 1;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(5) == 0) begin
         burst_left = $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // check every delivered transaction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         seen.outcome       = tqps_pkg::outcome_type'(rsp_outcome);
         seen.ident         = rsp_served_ident;
         seen.wait_time     = rsp_served_wait;
         seen.high_count    = rsp_high_count;
         seen.low_count     = rsp_low_count;
         seen.high_refused  = rsp_high_refused_total;
         seen.low_refused   = rsp_low_refused_total;
         seen.high_served   = rsp_high_served_total;
         seen.low_served    = rsp_low_served_total;
         seen.idle_ticks    = rsp_idle_total;
         seen.high_wait_sum = rsp_high_wait_total;
         seen.low_wait_sum  = rsp_low_wait_total;
         board.check_result(seen);
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int push_pct;
      int n_items;
      logic [tqps_pkg::FILL_W-1:0] phase_limit;
      board = new();
      stamp = tqps_pkg::TIME_W'($urandom);
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // idle ticks, then arrival and tick times that wrap around
      send_item(CMD_TICK, 16'h0000, 32'h0000_0000);
      send_item(CMD_TICK_ALT, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(CMD_HIGH_REQ, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(CMD_LOW_REQ, 16'h0000, 32'h0000_0000);
      send_item(CMD_LOW_REQ, 16'h5A5A, 32'hFFFF_FFF0);
      send_item(CMD_HIGH_REQ, 16'h8000, 32'h0000_0000);
      send_item(CMD_TICK, 16'h1234, 32'h0000_0005);
      send_item(CMD_TICK_ALT, 16'h0000, 32'hFFFF_FFFF);
      send_item(CMD_TICK, 16'h0000, 32'h8000_0000);
      send_item(CMD_TICK, 16'hFFFF, 32'h0000_0003);
      send_item(CMD_TICK, 16'h0000, 32'h0000_0000);

      // small limit, then zero limit with entries still held, then limit at fill
      write_limit(5'd2);
      send_item(CMD_HIGH_REQ, 16'h0001, 32'd100);
      send_item(CMD_HIGH_REQ, 16'h0002, 32'd101);
      send_item(CMD_LOW_REQ, 16'h0003, 32'd102);
      write_limit(5'd0);
      send_item(CMD_HIGH_REQ, 16'h0004, 32'd110);
      send_item(CMD_LOW_REQ, 16'h0005, 32'd111);
      send_item(CMD_TICK, 16'h0000, 32'd200);
      send_item(CMD_HIGH_REQ, 16'h0006, 32'd201);
      write_limit(5'd1);
      send_item(CMD_HIGH_REQ, 16'h0007, 32'd210);
      send_item(CMD_TICK, 16'h0000, 32'd220);
      send_item(CMD_HIGH_REQ, 16'h0008, 32'd300);
      send_item(CMD_TICK, 16'h0000, 32'd310);
      send_item(CMD_TICK_ALT, 16'h0000, 32'd320);
      send_item(CMD_TICK, 16'h0000, 32'd330);

      // random phases, each under its own limit and mix of requests and ticks
      for (int phase = 0; phase < 8; phase++) begin
         n_items = 90;
         quiet = 1'b0;
         case (phase)
            0: begin phase_limit = 5'd31; push_pct = 75; end
            1: begin phase_limit = 5'd31; push_pct = 30; end
            2: begin phase_limit = 5'd16; push_pct = 65; end
            3: begin phase_limit = 5'd17; push_pct = 50; quiet = 1'b1; end
            4: begin phase_limit = 5'd1;  push_pct = 60; end
            5: begin phase_limit = 5'd0;  push_pct = 60; n_items = 40; end
            6: begin
               phase_limit = tqps_pkg::FILL_W'($urandom_range(2, 15));
               push_pct = 70;
            end
            default: begin phase_limit = 5'd16; push_pct = 40; quiet = 1'b1; end
         endcase
         write_limit(phase_limit);
         for (int i = 0; i < n_items; i++) begin
            // long result hold-off while requests keep coming
            if (phase == 2 && i == 10)
               hold_req = HOLD_CYCLES;
            // sender waits for everything outstanding mid-phase
            if (phase == 6 && i == 45)
               pause_until_drained();
            random_item(push_pct);
         end
      end

      pause_until_drained();
      quiet = 1'b1;
      repeat (6) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

[two_queue_priority_server.f]
hdl/tqps_pkg.sv
hdl/tqps_queue.sv
hdl/two_queue_priority_server.sv
sim/two_queue_priority_server_tb.sv
